// ===== rtl/core/ncpc_pkg.sv =====
// ============================================================================
// ncpc_pkg : shared types and constants of the nearest class point classifier
// Holds status codes, mode codes, register indexes and controller states.
// ============================================================================
package ncpc_pkg;

    // Number of label slots; the label field is six bits wide.
    localparam int MAX_LABELS = 64;

    localparam logic [1:0] MODE_CLASSIFY = 2'd0;
    localparam logic [1:0] MODE_INSERT   = 2'd1;
    localparam logic [1:0] MODE_REMOVE   = 2'd2;
    localparam logic [1:0] MODE_UNUSED   = 2'd3;

    localparam logic [2:0] ST_LABELLED = 3'd0;
    localparam logic [2:0] ST_NO_LABEL = 3'd1;
    localparam logic [2:0] ST_TOO_FEW  = 3'd2;
    localparam logic [2:0] ST_STORED   = 3'd3;
    localparam logic [2:0] ST_IGNORED  = 3'd4;
    localparam logic [2:0] ST_FULL     = 3'd5;
    localparam logic [2:0] ST_REMOVED  = 3'd6;

    localparam logic REG_LABEL_COUNT   = 1'b0;
    localparam logic REG_UNKNOWN_LABEL = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_SCAN_DRAIN,
        S_LBL,
        S_LBL_DRAIN,
        S_DIV,
        S_DONE,
        S_OUT
    } t_state;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;      // capture the input item
        logic scan_clr;  // clear scan and label state
        logic scan_go;   // issue one store read
        logic lbl_go;    // issue one label table read
        logic div_start; // start the ratio divider
        logic div_step;  // one divider iteration
        logic finish;    // form the result
    } t_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic scan_last;
        logic scan_busy;
        logic lbl_last;
        logic lbl_busy;
        logic div_done;
        logic too_few;
        logic classify;
    } t_stat;

endpackage

// ===== rtl/core/nearest_class_point_classifier_top.sv =====
// ============================================================================
// nearest_class_point_classifier_top : nearest class point classifier
// Labelled point store with nearest-label classification and confidence.
// ============================================================================
// One item is in work at a time, and the input is ready only while the
// controller is idle. Insert and remove walk every store entry to look up the
// id and the lowest free slot, then drain the three-stage read and distance
// pipeline before the result is formed and handed off. A classify makes the
// same walk and folds each distance into a per-label minimum, then walks the
// labels in use and runs a 16-step restoring divider. A classify with fewer
// than two labels skips the walks and the divider, and the unused mode three
// goes straight to forming its result. Once the result is in the output
// register the controller returns to idle, so a new item may be taken while
// that result waits; a result that is still waiting holds the next one, and so
// the input, until its transfer completes. Configuration may be written only
// while no item is in flight.
module nearest_class_point_classifier_top import ncpc_pkg::*; #(
    parameter int STORE_DEPTH = 256,
    parameter int COORD_BITS  = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // mode[1:0], point_id[17:2], label_index[23:18], pos_x, pos_y, pos_z, zero fill
    input  logic [((24 + 3 * COORD_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[2:0], label[8:3], confidence[24:9], zero fill to 32 bits
    output logic [31:0] m_axis_tdata,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [6:0]  i_cfg_data
);

    localparam int CB = COORD_BITS;

    logic [6:0] r_label_count, r_unknown_label;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_label_count   <= 7'd2;
            r_unknown_label <= 7'd64;
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_LABEL_COUNT) r_label_count <= i_cfg_data;
            else                                r_unknown_label <= i_cfg_data;
        end
    end

    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_idle, w_out_load;
    logic  w_in_fire;
    logic  r_out_v;
    logic [2:0]  w_status;
    logic [5:0]  w_best;
    logic [15:0] w_conf;

    assign s_axis_tready = w_idle;
    assign w_in_fire     = s_axis_tvalid & w_idle;

    ncpc_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_fire     (w_in_fire),
        .i_needs_scan  (s_axis_tdata[1:0] != MODE_UNUSED),
        .i_out_free    (!r_out_v || m_axis_tready),
        .i_stat        (w_stat),
        .o_cmd         (w_cmd),
        .o_idle        (w_idle),
        .o_out_load    (w_out_load)
    );

    ncpc_datapath #(
        .STORE_DEPTH (STORE_DEPTH),
        .COORD_BITS  (COORD_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_mode          (s_axis_tdata[1:0]),
        .i_point_id      (s_axis_tdata[17:2]),
        .i_label_index   (s_axis_tdata[23:18]),
        .i_pos_x         (s_axis_tdata[24 +: CB]),
        .i_pos_y         (s_axis_tdata[24 + CB +: CB]),
        .i_pos_z         (s_axis_tdata[24 + 2 * CB +: CB]),
        .i_label_count   (r_label_count),
        .i_unknown_label (r_unknown_label),
        .o_stat          (w_stat),
        .o_status        (w_status),
        .o_win_label     (w_best),
        .o_confidence    (w_conf)
    );

    // Output register: holds one result until its transfer completes.
    logic [24:0] r_out_d;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_out_load) begin
            r_out_v <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_v <= 1'b0;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_out_load) r_out_d <= {w_conf, w_best, w_status};
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = {7'd0, r_out_d};

endmodule

// ===== rtl/core/ncpc_ctrl.sv =====
// ============================================================================
// ncpc_ctrl : sequencer of the classifier
// Steps the datapath through store scan, label scan and division.
// ============================================================================
module ncpc_ctrl import ncpc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_fire,
    input  logic  i_needs_scan,
    input  logic  i_out_free,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_idle,
    output logic  o_out_load
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_idle     = 1'b0;
        o_out_load = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_idle = 1'b1;
                if (i_in_fire) begin
                    o_cmd.load     = 1'b1;
                    o_cmd.scan_clr = 1'b1;
                    n_state = i_needs_scan ? S_SCAN : S_DONE;
                end
            end
            S_SCAN: begin
                if (i_stat.too_few) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.scan_go = 1'b1;
                    if (i_stat.scan_last) n_state = S_SCAN_DRAIN;
                end
            end
            S_SCAN_DRAIN: begin
                if (!i_stat.scan_busy) n_state = i_stat.classify ? S_LBL : S_DONE;
            end
            S_LBL: begin
                o_cmd.lbl_go = 1'b1;
                if (i_stat.lbl_last) n_state = S_LBL_DRAIN;
            end
            S_LBL_DRAIN: begin
                if (!i_stat.lbl_busy) begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_done) n_state = S_DONE;
            end
            S_DONE: begin
                o_cmd.finish = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_out_free) begin
                    o_out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// ===== rtl/core/ncpc_datapath.sv =====
// ============================================================================
// ncpc_datapath : store, distance pipeline, label table and divider
// Holds the training store and computes one result per item under command.
// ============================================================================
module ncpc_datapath import ncpc_pkg::*; #(
    parameter int STORE_DEPTH = 256,
    parameter int COORD_BITS  = 24
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_cmd                         i_cmd,
    input  logic [1:0]                   i_mode,
    input  logic [15:0]                  i_point_id,
    input  logic [5:0]                   i_label_index,
    input  logic signed [COORD_BITS-1:0] i_pos_x,
    input  logic signed [COORD_BITS-1:0] i_pos_y,
    input  logic signed [COORD_BITS-1:0] i_pos_z,
    input  logic [6:0]                   i_label_count,
    input  logic [6:0]                   i_unknown_label,
    output t_stat                        o_stat,
    output logic [2:0]                   o_status,
    output logic [5:0]                   o_win_label,
    output logic [15:0]                  o_confidence
);

    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int LW = (MAX_LABELS > 1) ? $clog2(MAX_LABELS) : 1;
    localparam int DW = COORD_BITS + 1;
    localparam int SW = 2 * DW;
    localparam int TW = SW + 2;

    // Label field is 6 bits wide; labels never exceed 63.
    localparam int LBW = 6;

    logic [1:0]                   r_mode;
    logic [15:0]                  r_id;
    logic [LBW-1:0]               r_lab;
    logic signed [COORD_BITS-1:0] r_px, r_py, r_pz;

    // Training store, valid bits in flops.
    logic [STORE_DEPTH-1:0]       r_valid;
    logic [15:0]                  m_id  [STORE_DEPTH];
    logic [LBW-1:0]               m_lab [STORE_DEPTH];
    logic signed [COORD_BITS-1:0] m_x   [STORE_DEPTH];
    logic signed [COORD_BITS-1:0] m_y   [STORE_DEPTH];
    logic signed [COORD_BITS-1:0] m_z   [STORE_DEPTH];

    // Effective label count, clamped.
    logic [8:0] w_nl;
    assign w_nl = (32'(i_label_count) > MAX_LABELS) ? 9'(MAX_LABELS) : 9'(i_label_count);
    assign o_stat.too_few  = (r_mode == MODE_CLASSIFY) && (w_nl < 9'd2);
    assign o_stat.classify = (r_mode == MODE_CLASSIFY);

    // Insert / remove: id match and lowest free slot found during the store walk.
    logic        r_found;
    logic [AW-1:0] r_found_idx;
    logic        r_free;
    logic [AW-1:0] r_free_idx;

    // Scan address, stage valids.
    logic [AW:0]   r_sa;
    logic          r_s1_v, r_s2_v, r_s3_v;
    logic [AW-1:0] r_s1_a;
    logic [15:0]   r_s1_id;
    logic [LBW-1:0] r_s1_lab, r_s2_lab, r_s3_lab;
    logic signed [COORD_BITS-1:0] r_s1_x, r_s1_y, r_s1_z;
    logic          r_s1_ok, r_s2_ok, r_s3_ok;
    logic [DW-1:0] r_dx, r_dy, r_dz;
    logic [SW-1:0] r_qx, r_qy, r_qz;
    logic [TW-1:0] w_dist;

    assign o_stat.scan_last = (r_sa == (AW+1)'(STORE_DEPTH - 1));
    assign o_stat.scan_busy = r_s1_v | r_s2_v | r_s3_v;

    // Label minimum table (memory) and per-label has-point bits.
    logic [TW-1:0]         m_lmin [MAX_LABELS];
    logic [MAX_LABELS-1:0] r_has;
    logic [TW-1:0]         r_lmin_rd;

    // Registered read of the label minimum for stage 3, with forwarding of an
    // update to the same label made at the same edge.
    logic [TW-1:0] r_s3_cur;
    logic          w_cur_has;
    logic          w_lmin_we;

    function automatic logic [DW-1:0] absdiff(input logic signed [COORD_BITS-1:0] a,
                                               input logic signed [COORD_BITS-1:0] b);
        logic signed [DW-1:0] d;
        d = DW'(a) - DW'(b);
        absdiff = d[DW-1] ? DW'(-d) : DW'(d);
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= i_mode;
            r_id   <= i_point_id;
            r_lab  <= i_label_index;
            r_px   <= i_pos_x;
            r_py   <= i_pos_y;
            r_pz   <= i_pos_z;
        end
    end

    // Stage 1: store read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sa   <= '0;
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
        end else begin
            if (i_cmd.scan_clr) r_sa <= '0;
            else if (i_cmd.scan_go) r_sa <= r_sa + 1'b1;
            r_s1_v <= i_cmd.scan_go;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_a   <= r_sa[AW-1:0];
        r_s1_id  <= m_id[r_sa[AW-1:0]];
        r_s1_lab <= m_lab[r_sa[AW-1:0]];
        r_s1_x   <= m_x[r_sa[AW-1:0]];
        r_s1_y   <= m_y[r_sa[AW-1:0]];
        r_s1_z   <= m_z[r_sa[AW-1:0]];
        r_s1_ok  <= r_valid[r_sa[AW-1:0]];
        // Stage 2: differences.
        r_dx     <= absdiff(r_px, r_s1_x);
        r_dy     <= absdiff(r_py, r_s1_y);
        r_dz     <= absdiff(r_pz, r_s1_z);
        r_s2_lab <= r_s1_lab;
        r_s2_ok  <= r_s1_ok && (9'(r_s1_lab) < w_nl);
        // Stage 3: squares, then sum.
        r_qx     <= SW'(r_dx) * SW'(r_dx);
        r_qy     <= SW'(r_dy) * SW'(r_dy);
        r_qz     <= SW'(r_dz) * SW'(r_dz);
        r_s3_lab <= r_s2_lab;
        r_s3_ok  <= r_s2_ok;
        r_s3_cur <= (w_lmin_we && r_s3_lab == r_s2_lab) ? w_dist
                                                        : m_lmin[r_s2_lab[LW-1:0]];
    end

    assign w_dist = TW'(r_qx) + TW'(r_qy) + TW'(r_qz);

    // Id lookup and lowest free slot, taken from the stage 1 read data as the
    // walk goes up the store.
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_clr) begin
            r_found     <= 1'b0;
            r_found_idx <= '0;
            r_free      <= 1'b0;
            r_free_idx  <= '0;
        end else if (r_s1_v) begin
            if (r_s1_ok && r_s1_id == r_id && !r_found) begin
                r_found     <= 1'b1;
                r_found_idx <= r_s1_a;
            end
            if (!r_s1_ok && !r_free) begin
                r_free     <= 1'b1;
                r_free_idx <= r_s1_a;
            end
        end
    end

    // Label table update at the end of the distance pipe.
    assign w_cur_has = r_has[r_s3_lab[LW-1:0]];
    assign w_lmin_we = r_s3_v && r_s3_ok && (!w_cur_has || w_dist < r_s3_cur);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_has <= '0;
        end else if (i_cmd.scan_clr) begin
            r_has <= '0;
        end else if (r_s3_v && r_s3_ok) begin
            r_has[r_s3_lab[LW-1:0]] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_lmin_we)
            m_lmin[r_s3_lab[LW-1:0]] <= w_dist;
    end

    // Store writes.
    logic w_do_insert;
    assign w_do_insert = (r_mode == MODE_INSERT) && (7'(r_lab) != i_unknown_label) &&
                         !r_found && r_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.finish) begin
            if (w_do_insert)
                r_valid[r_free_idx] <= 1'b1;
            else if (r_mode == MODE_REMOVE && r_found)
                r_valid[r_found_idx] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish && w_do_insert) begin
            m_id[r_free_idx]  <= r_id;
            m_lab[r_free_idx] <= r_lab;
            m_x[r_free_idx]   <= r_px;
            m_y[r_free_idx]   <= r_py;
            m_z[r_free_idx]   <= r_pz;
        end
    end

    // Label walk: best and second best.
    logic [LW:0]    r_la;
    logic           r_l1_v;
    logic [LW-1:0]  r_l1_i;
    logic           r_l1_has;
    logic           r_hb, r_hs;
    logic [TW-1:0]  r_b, r_s;
    logic [LBW-1:0] r_best;

    assign o_stat.lbl_last = (9'(r_la) + 9'd1 >= w_nl);
    assign o_stat.lbl_busy = r_l1_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_la   <= '0;
            r_l1_v <= 1'b0;
        end else begin
            if (i_cmd.scan_clr) r_la <= '0;
            else if (i_cmd.lbl_go) r_la <= r_la + 1'b1;
            r_l1_v <= i_cmd.lbl_go;
        end
    end

    always_ff @(posedge i_clk) begin
        r_l1_i    <= r_la[LW-1:0];
        r_l1_has  <= r_has[r_la[LW-1:0]];
        r_lmin_rd <= m_lmin[r_la[LW-1:0]];
        if (i_cmd.scan_clr) begin
            r_hb <= 1'b0;
            r_hs <= 1'b0;
            r_b  <= '0;
            r_s  <= '0;
            r_best <= '0;
        end else if (r_l1_v && r_l1_has) begin
            if (!r_hb || r_lmin_rd < r_b) begin
                if (r_hb) begin
                    r_s  <= r_b;
                    r_hs <= 1'b1;
                end
                r_b    <= r_lmin_rd;
                r_best <= LBW'(r_l1_i);
                r_hb   <= 1'b1;
            end else if (!r_hs || r_lmin_rd < r_s) begin
                r_s  <= r_lmin_rd;
                r_hs <= 1'b1;
            end
        end
    end

    // Restoring divider, 16 quotient bits, one per cycle.
    logic [TW:0]   r_n, r_d;
    logic [15:0]   r_q;
    logic [4:0]    r_dc;
    logic [TW:0]   w_n2;
    assign w_n2 = {r_n[TW-1:0], 1'b0};
    assign o_stat.div_done = (r_dc == 5'd15);

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_n  <= (TW+1)'(r_s - r_b);
            r_d  <= (TW+1)'(r_s) + (TW+1)'(r_b);
            r_q  <= '0;
            r_dc <= '0;
        end else if (i_cmd.div_step) begin
            r_dc <= r_dc + 5'd1;
            if (w_n2 >= r_d) begin
                r_n <= w_n2 - r_d;
                r_q <= {r_q[14:0], 1'b1};
            end else begin
                r_n <= w_n2;
                r_q <= {r_q[14:0], 1'b0};
            end
        end
    end

    // Result formation.
    logic [15:0] w_qf;
    assign w_qf = (w_n2 >= r_d) ? {r_q[14:0], 1'b1} : {r_q[14:0], 1'b0};
    logic [15:0] r_qfin;
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_step && o_stat.div_done) r_qfin <= w_qf;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_win_label  <= '0;
            o_confidence <= '0;
            case (r_mode)
                MODE_CLASSIFY: begin
                    if (o_stat.too_few) begin
                        o_status <= ST_TOO_FEW;
                    end else if (!r_hb) begin
                        o_status <= ST_NO_LABEL;
                    end else begin
                        o_status    <= ST_LABELLED;
                        o_win_label <= r_best;
                        if (!r_hs)            o_confidence <= 16'd1;
                        else if (r_s == '0)   o_confidence <= 16'd32768;
                        else if (r_b == '0)   o_confidence <= 16'd65535;
                        else                  o_confidence <= r_qfin;
                    end
                end
                MODE_INSERT: begin
                    if (7'(r_lab) == i_unknown_label || r_found) o_status <= ST_IGNORED;
                    else if (!r_free) o_status <= ST_FULL;
                    else              o_status <= ST_STORED;
                end
                MODE_REMOVE: o_status <= ST_REMOVED;
                default:     o_status <= ST_IGNORED;
            endcase
        end
    end

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top : stream-level test of the nearest class point classifier
// Drives insert, remove, classify and unused-mode items over the input stream
// and checks every result against a behavioral predictor held in a small scoreboard.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import ncpc_pkg::*;

    localparam int DEPTH      = 256;
    localparam int LABELS     = 64;
    localparam int WDOG_LIMIT = 6000;

    typedef struct {
        logic [1:0]         mode;
        logic [15:0]        id;
        logic [5:0]         lbl;
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic signed [23:0] z;
    } pt_item_t;

    typedef struct {
        logic [2:0]  status;
        logic [5:0]  best;
        logic [15:0] conf;
    } verdict_t;

    // Scoreboard: owns a copy of the training store and of the registers,
    // predicts each result when its item is accepted and checks results.
    class verdict_board;
        logic [6:0]         lcount;
        logic [6:0]         unk;
        bit                 valid [DEPTH];
        logic [15:0]        ids   [DEPTH];
        logic [5:0]         lbls  [DEPTH];
        logic signed [23:0] ex    [DEPTH];
        logic signed [23:0] ey    [DEPTH];
        logic signed [23:0] ez    [DEPTH];
        verdict_t           pending[$];
        int                 errors;

        function new();
            lcount = 7'd2;
            unk    = 7'd64;
            errors = 0;
            foreach (valid[i]) valid[i] = 0;
        endfunction

        function void set_reg(logic idx, logic [6:0] val);
            if (idx == REG_LABEL_COUNT) lcount = val;
            else unk = val;
        endfunction

        function longint unsigned sq(logic signed [23:0] a, logic signed [23:0] b);
            longint d;
            d = longint'(a) - longint'(b);
            if (d < 0) d = -d;
            return longint'(d * d);
        endfunction

        function logic [15:0] ratio(longint unsigned n, longint unsigned d);
            logic [15:0] q;
            q = 0;
            while ((d >> 60) != 0) begin
                n = n >> 1;
                d = d >> 1;
            end
            if (d == 0 || n >= d) return 16'hFFFF;
            for (int i = 0; i < 16; i++) begin
                n = n << 1;
                q = q << 1;
                if (n >= d) begin
                    n = n - d;
                    q[0] = 1'b1;
                end
            end
            return q;
        endfunction

        function int find_id(logic [15:0] id);
            for (int i = 0; i < DEPTH; i++)
                if (valid[i] && ids[i] == id) return i;
            return -1;
        endfunction

        function verdict_t classify(pt_item_t it);
            verdict_t        r;
            int              nl;
            bit              has [LABELS];
            longint unsigned mind [LABELS];
            longint unsigned sqd, b, s;
            bit              hb, hs;
            int              best;
            r = '{ST_LABELLED, 6'd0, 16'd0};
            nl = (lcount > LABELS) ? LABELS : int'(lcount);
            if (nl < 2) begin
                r.status = ST_TOO_FEW;
                return r;
            end
            foreach (has[i]) has[i] = 0;
            for (int i = 0; i < DEPTH; i++) begin
                if (!valid[i] || lbls[i] >= nl) continue;
                sqd = sq(it.x, ex[i]) + sq(it.y, ey[i]) + sq(it.z, ez[i]);
                if (!has[lbls[i]] || sqd < mind[lbls[i]]) begin
                    mind[lbls[i]] = sqd;
                    has[lbls[i]]  = 1;
                end
            end
            hb = 0; hs = 0; b = 0; s = 0; best = 0;
            for (int l = 0; l < nl; l++) begin
                if (!has[l]) continue;
                if (!hb || mind[l] < b) begin
                    if (hb) begin
                        s  = b;
                        hs = 1;
                    end
                    b = mind[l];
                    best = l;
                    hb = 1;
                end else if (!hs || mind[l] < s) begin
                    s  = mind[l];
                    hs = 1;
                end
            end
            if (!hb) begin
                r.status = ST_NO_LABEL;
                return r;
            end
            r.best = best[5:0];
            if (!hs) r.conf = 16'd1;
            else if (s == 0) r.conf = 16'd32768;
            else if (b == 0) r.conf = 16'hFFFF;
            else r.conf = ratio(s - b, s + b);
            return r;
        endfunction

        // Called for each accepted input transfer.
        function void note_item(pt_item_t it);
            verdict_t r;
            int       k;
            r = '{ST_IGNORED, 6'd0, 16'd0};
            if (it.mode == MODE_CLASSIFY) begin
                r = classify(it);
            end else if (it.mode == MODE_INSERT) begin
                if ({1'b0, it.lbl} != unk && find_id(it.id) < 0) begin
                    r.status = ST_FULL;
                    for (k = 0; k < DEPTH; k++) begin
                        if (!valid[k]) begin
                            valid[k] = 1;
                            ids[k]   = it.id;
                            lbls[k]  = it.lbl;
                            ex[k]    = it.x;
                            ey[k]    = it.y;
                            ez[k]    = it.z;
                            r.status = ST_STORED;
                            break;
                        end
                    end
                end
            end else if (it.mode == MODE_REMOVE) begin
                k = find_id(it.id);
                if (k >= 0) valid[k] = 0;
                r.status = ST_REMOVED;
            end
            pending.push_back(r);
        endfunction

        // Called for each accepted output transfer.
        function void check_verdict(verdict_t act);
            verdict_t exp_r;
            if (pending.size() == 0) begin
                $error("result with no item outstanding: status %0d", act.status);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (act.status !== exp_r.status) begin
                $error("status: expected %0d, actual %0d", exp_r.status, act.status);
                errors++;
            end
            if (act.best !== exp_r.best) begin
                $error("pred_label: expected %0d, actual %0d", exp_r.best, act.best);
                errors++;
            end
            if (act.conf !== exp_r.conf) begin
                $error("confidence: expected %0d, actual %0d", exp_r.conf, act.conf);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [6:0]  i_cfg_data;

    verdict_board board;
    int           tx_idle;   // percent of cycles the sender holds off
    int           rx_stall;  // percent of cycles the receiver stalls
    int           quiet_cycles;

    nearest_class_point_classifier_top dut (.*);

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // The receiver decides its ready at each falling edge.
    always @(negedge i_clk) begin
        m_axis_tready = ($urandom_range(99) >= rx_stall);
    end

    // Result checking and the watchdog share the rising edge.
    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready && i_rst_n) begin
            board.check_verdict('{m_axis_tdata[2:0], m_axis_tdata[8:3],
                                  m_axis_tdata[24:9]});
        end
        if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Present one item; it is noted in the scoreboard on the accepting edge.
    task automatic push_item(pt_item_t it);
        forever begin
            @(negedge i_clk);
            if ($urandom_range(99) < tx_idle) begin
                s_axis_tvalid = 1'b0;
            end else begin
                s_axis_tvalid = 1'b1;
                s_axis_tdata  = {it.z, it.y, it.x, it.lbl, it.id, it.mode};
                break;
            end
        end
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_item(it);
    endtask

    task automatic push(logic [1:0] m, logic [15:0] id, logic [5:0] l,
                        logic signed [23:0] x, logic signed [23:0] y,
                        logic signed [23:0] z);
        pt_item_t it;
        it = '{m, id, l, x, y, z};
        push_item(it);
    endtask

    // Drop valid and wait until every outstanding result has come back.
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (board.pending.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    // Registers are only written with the block idle, so drain first.
    task automatic write_reg(logic idx, logic [6:0] val);
        drain();
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        board.set_reg(idx, val);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // Coordinates: small half the time so that ties and zero distances happen,
    // with full-range values and the extremes mixed in.
    function automatic logic signed [23:0] rand_coord();
        case ($urandom_range(7))
            0, 1:    return 24'($urandom());
            2:       return 24'sh800000;
            3:       return 24'sh7FFFFF;
            default: return $signed(24'($urandom_range(32))) - 24'sd16;
        endcase
    endfunction

    function automatic pt_item_t rand_item();
        pt_item_t it;
        int       r, top;
        r   = $urandom_range(99);
        top = (board.lcount > 62) ? 63 : int'(board.lcount) + 1;
        if (r < 40) it.mode = MODE_INSERT;
        else if (r < 75) it.mode = MODE_CLASSIFY;
        else if (r < 95) it.mode = MODE_REMOVE;
        else it.mode = MODE_UNUSED;
        it.id  = ($urandom_range(7) == 0) ? 16'($urandom()) : 16'($urandom_range(300));
        it.lbl = ($urandom_range(7) == 0) ? 6'($urandom()) : 6'($urandom_range(top));
        it.x   = rand_coord();
        it.y   = rand_coord();
        it.z   = rand_coord();
        return it;
    endfunction

    localparam logic [6:0] PH_LCOUNT [8] = '{7'd2, 7'd5, 7'd64, 7'd127,
                                             7'd3, 7'd64, 7'd0, 7'd8};
    localparam logic [6:0] PH_UNK    [8] = '{7'd64, 7'd0, 7'd3, 7'd127,
                                             7'd1, 7'd64, 7'd2, 7'd127};
    localparam int PH_IDLE  [4] = '{0, 87, 0, 28};
    localparam int PH_STALL [4] = '{0, 0, 87, 28};

    initial begin
        board         = new();
        tx_idle       = 0;
        rx_stall      = 0;
        quiet_cycles  = 0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = REG_LABEL_COUNT;
        i_cfg_data    = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part, at the reset register values.
        push(MODE_CLASSIFY, 16'd0, 6'd0, 24'sd0, 24'sd0, 24'sd0);   // empty store
        push(MODE_INSERT, 16'd0, 6'd0, 24'sd0, 24'sd0, 24'sd0);
        push(MODE_CLASSIFY, 16'd0, 6'd0, 24'sd5, 24'sd0, 24'sd0);   // one label only
        push(MODE_INSERT, 16'd0, 6'd1, 24'sd9, 24'sd9, 24'sd9);     // duplicate id
        push(MODE_INSERT, 16'hFFFF, 6'd1, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
        push(MODE_CLASSIFY, 16'd0, 6'd0, 24'sh800000, 24'sh800000, 24'sh800000);
        push(MODE_CLASSIFY, 16'd0, 6'd0, 24'sd0, 24'sd0, 24'sd0);   // best at zero
        push(MODE_INSERT, 16'd2, 6'd1, 24'sd0, 24'sd0, 24'sd0);
        push(MODE_CLASSIFY, 16'hFFFF, 6'h3F, 24'sd0, 24'sd0, 24'sd0); // tie, second zero
        push(MODE_INSERT, 16'd3, 6'd63, 24'sd1, 24'sd1, 24'sd1);    // label out of range
        push(MODE_CLASSIFY, 16'd0, 6'd0, 24'sd1, 24'sd1, 24'sd1);
        push(MODE_REMOVE, 16'd2, 6'd0, 24'sd0, 24'sd0, 24'sd0);
        push(MODE_REMOVE, 16'd1234, 6'd0, 24'sd0, 24'sd0, 24'sd0);  // absent id
        push(MODE_UNUSED, 16'hFFFF, 6'h3F, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF);
        push(MODE_CLASSIFY, 16'd0, 6'd0, 24'sd100, 24'sd0, 24'sd0);
        write_reg(REG_LABEL_COUNT, 7'd1);
        push(MODE_CLASSIFY, 16'd0, 6'd0, 24'sd0, 24'sd0, 24'sd0);   // too few labels
        write_reg(REG_LABEL_COUNT, 7'd127);
        write_reg(REG_UNKNOWN_LABEL, 7'd5);
        push(MODE_INSERT, 16'd7, 6'd5, 24'sd0, 24'sd0, 24'sd0);     // unknown label
        push(MODE_INSERT, 16'd8, 6'd63, 24'sd2, 24'sd2, 24'sd2);
        push(MODE_CLASSIFY, 16'd0, 6'd0, 24'sd2, 24'sd3, 24'sd2);

        // Fill the store past its depth, then classify against a full store.
        for (int k = 0; k < 262; k++)
            push(MODE_INSERT, 16'(1000 + k), 6'($urandom_range(63)),
                 rand_coord(), rand_coord(), rand_coord());
        push(MODE_CLASSIFY, 16'd0, 6'd0, rand_coord(), rand_coord(), rand_coord());
        for (int k = 0; k < 262; k++)
            push(MODE_REMOVE, 16'(1000 + k), 6'd0, 24'sd0, 24'sd0, 24'sd0);

        // Random phases: own register setting each, one of four idling mixes.
        for (int p = 0; p < 8; p++) begin
            tx_idle  = 0;
            rx_stall = 0;
            write_reg(REG_LABEL_COUNT, PH_LCOUNT[p]);
            write_reg(REG_UNKNOWN_LABEL, PH_UNK[p]);
            tx_idle  = PH_IDLE[p % 4];
            rx_stall = PH_STALL[p % 4];
            for (int n = 0; n < 140; n++) begin
                push_item(rand_item());
                if (p == 3 && n == 70) drain();
            end
        end

        drain();
        repeat (400) @(posedge i_clk);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/ncpc_pkg.sv
rtl/core/ncpc_ctrl.sv
rtl/core/ncpc_datapath.sv
rtl/core/nearest_class_point_classifier_top.sv
verif/tb_top.sv
